// ===== design/bmsi_pkg.sv =====
// Shared types and constants for the bank mapper with scanline IRQ counter.
// Used by every module of the block; has no dependencies.
package bmsi_pkg;

  localparam int PRG_BANK_BITS = 8;
  localparam int CHR_BANK_BITS = 8;
  localparam int MEM_ADDR_W    = 21;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_PPU   = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    TGT_NONE = 2'd0,
    TGT_PRG  = 2'd1,
    TGT_WRAM = 2'd2,
    TGT_CHR  = 2'd3
  } target_t;

  // APB register indexes (byte address bits 3..2)
  typedef enum logic [1:0] {
    REG_FALLING_EDGE_MODE = 2'd0,
    REG_EDGE_DELAY        = 2'd1,
    REG_PRG_BANK_MASK     = 2'd2,
    REG_CHR_BANK_MASK     = 2'd3
  } cfg_reg_t;

  typedef logic [7:0][7:0] bank_regs_t;

  typedef struct packed {
    logic       falling_edge_mode;
    logic [7:0] edge_delay;
    logic [7:0] prg_bank_mask;
    logic [7:0] chr_bank_mask;
  } cfg_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] cpu_addr;
    logic [7:0]  data;
    logic [13:0] ppu_addr;
  } item_t;

  // Bank state that the address mapping reads
  typedef struct packed {
    bank_regs_t bank_regs;
    logic [7:0] bank_select;
  } map_view_t;

endpackage

// ===== design/bank_mapper_scanline_irq_unit.sv =====
// Bank mapper with A12 edge scanline IRQ counter: top level with stream ports.
// Depends on bmsi_pkg, bmsi_cfg, bmsi_state and bmsi_map.
//
// Usage:
//   Slave stream (s_*) takes one bus event per item: s_tuser carries the kind
//   (CPU write, CPU read, PPU access, CPU cycle tick), s_tdata the addresses
//   and write data. Master stream (m_*) returns one result per item: m_tuser
//   is the target memory, m_tdata the IRQ level, mapped address and mirroring.
//   Configuration goes through the APB port (4 registers at 0x0, 0x4, 0x8, 0xC);
//   the user must write it only while no item is in flight; the block does not enforce this.
//   Path: an accepted item sits in the input register; its result is loaded
//   into the output register once that register can take it (m_tvalid low or
//   m_tready high), and is then offered on m_tvalid.
//   Throughput: one item per cycle while m_tready is high; the single pass of map
//   and counter logic between the input and output registers sets this figure.
//   Stall: while m_tready is low and a result waits, the input register holds
//   one more item; s_tready drops only when both are full.
//   Reset: rst clears the valid flags, bank registers (bank 7 reads 1), the
//   IRQ counter and the configuration to its defaults.
module bank_mapper_scanline_irq_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // cpu_addr[15:0], data[23:16], ppu_addr[37:24], zero pad
  input  logic [1:0]  s_tuser,   // op[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // irq[0], mem_addr[21:1], mirror_horizontal[22], zero pad
  output logic [1:0]  m_tuser,   // target[1:0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bmsi_pkg::*;

  cfg_t      cfg;
  item_t     in_item;
  logic      in_valid;
  logic      advance;
  map_view_t view;
  logic      irq_after, mirror_after;
  target_t   target;
  logic [MEM_ADDR_W-1:0] mem_addr;

  logic                  out_irq;
  target_t               out_target;
  logic [MEM_ADDR_W-1:0] out_addr;
  logic                  out_mirror;

  assign advance  = ~m_tvalid | m_tready;
  assign s_tready = ~in_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      in_item.op       <= op_t'(s_tuser);
      in_item.cpu_addr <= s_tdata[15:0];
      in_item.data     <= s_tdata[23:16];
      in_item.ppu_addr <= s_tdata[37:24];
    end
  end

  bmsi_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bmsi_state u_state (
    .clk          (clk),
    .rst          (rst),
    .step         (in_valid & advance),
    .item         (in_item),
    .cfg          (cfg),
    .view         (view),
    .irq_after    (irq_after),
    .mirror_after (mirror_after)
  );

  bmsi_map u_map (
    .item     (in_item),
    .view     (view),
    .cfg      (cfg),
    .target   (target),
    .mem_addr (mem_addr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_irq    <= irq_after;
      out_target <= target;
      out_addr   <= mem_addr;
      out_mirror <= mirror_after;
    end
  end

  assign m_tdata = {1'b0, out_mirror, out_addr, out_irq};
  assign m_tuser = out_target;

endmodule

// ===== design/bmsi_cfg.sv =====
// APB configuration registers: edge mode, edge delay and the bank masks.
// Depends on bmsi_pkg.
module bmsi_cfg (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output bmsi_pkg::cfg_t cfg
);
  import bmsi_pkg::*;

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.falling_edge_mode <= 1'b0;
      cfg.edge_delay        <= 8'd3;
      cfg.prg_bank_mask     <= 8'hFF;
      cfg.chr_bank_mask     <= 8'hFF;
    end else if (wr) begin
      unique case (paddr[3:2])
        REG_FALLING_EDGE_MODE: cfg.falling_edge_mode <= pwdata[0];
        REG_EDGE_DELAY:        cfg.edge_delay        <= pwdata[7:0];
        REG_PRG_BANK_MASK:     cfg.prg_bank_mask     <= pwdata[7:0];
        REG_CHR_BANK_MASK:     cfg.chr_bank_mask     <= pwdata[7:0];
        default:               ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_FALLING_EDGE_MODE: prdata = {31'd0, cfg.falling_edge_mode};
      REG_EDGE_DELAY:        prdata = {24'd0, cfg.edge_delay};
      REG_PRG_BANK_MASK:     prdata = {24'd0, cfg.prg_bank_mask};
      REG_CHR_BANK_MASK:     prdata = {24'd0, cfg.chr_bank_mask};
      default:               prdata = 32'd0;
    endcase
  end

endmodule

// ===== design/bmsi_state.sv =====
// Mapper state: bank select, bank registers, mirroring and the A12 edge IRQ counter.
// Updated once per item taken from the input register. Depends on bmsi_pkg.
module bmsi_state (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  bmsi_pkg::item_t   item,
  input  bmsi_pkg::cfg_t    cfg,
  output bmsi_pkg::map_view_t view,
  output logic              irq_after,
  output logic              mirror_after
);
  import bmsi_pkg::*;

  bank_regs_t bank_regs, bank_regs_next;
  logic [7:0] bank_select, bank_select_next;
  logic [7:0] mirror_reg, mirror_reg_next;
  logic [7:0] irq_latch, irq_latch_next;
  logic       irq_reload, irq_reload_next;
  logic [7:0] irq_count, irq_count_next;
  logic       irq_enabled, irq_enabled_next;
  logic       irq_level, irq_level_next;
  // last_a12 holds A12 of the previous PPU access; the current A12 comes from the item
  logic       last_a12, last_a12_next;
  logic [7:0] low_count, low_count_next;

  logic [2:0] page_hi;
  logic       odd, a12, a12_edge;
  logic [7:0] count_stepped;

  assign page_hi = item.cpu_addr[15:13];
  assign odd     = item.cpu_addr[0];
  // addresses from 0x3000 up fold down to 0x2xxx, which has A12 low
  assign a12     = item.ppu_addr[12] & ~item.ppu_addr[13];
  assign a12_edge = cfg.falling_edge_mode ? (last_a12 & ~a12) : (~last_a12 & a12);

  always_comb begin
    if (irq_reload || irq_count == 8'd0) count_stepped = irq_latch;
    else                                 count_stepped = irq_count - 8'd1;
  end

  always_comb begin
    bank_regs_next   = bank_regs;
    bank_select_next = bank_select;
    mirror_reg_next  = mirror_reg;
    irq_latch_next   = irq_latch;
    irq_reload_next  = irq_reload;
    irq_count_next   = irq_count;
    irq_enabled_next = irq_enabled;
    irq_level_next   = irq_level;
    last_a12_next    = last_a12;
    low_count_next   = low_count;
    unique case (item.op)
      OP_WRITE: begin
        unique case (page_hi)
          3'b100: begin
            if (odd) bank_regs_next[bank_select[2:0]] = item.data;
            else     bank_select_next = item.data;
          end
          3'b101: begin
            if (!odd) mirror_reg_next = item.data;
          end
          3'b110: begin
            if (odd) begin
              irq_count_next  = 8'd0;
              irq_reload_next = 1'b1;
            end else begin
              irq_latch_next = item.data;
            end
          end
          3'b111: begin
            irq_enabled_next = odd;
            if (!odd) irq_level_next = 1'b0;
          end
          default: ;
        endcase
      end
      OP_PPU: begin
        if (a12_edge) begin
          if (low_count > cfg.edge_delay) begin
            irq_count_next  = count_stepped;
            irq_reload_next = 1'b0;
            if (count_stepped == 8'd0 && irq_enabled) irq_level_next = 1'b1;
          end
          low_count_next = 8'd0;
        end
        last_a12_next = a12;
      end
      OP_TICK: begin
        if (!last_a12 && low_count != 8'hFF) low_count_next = low_count + 8'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      // bank 7 resets to 1, all others to 0
      bank_regs    <= {8'd1, 56'd0};
      bank_select  <= '0;
      mirror_reg   <= '0;
      irq_latch    <= '0;
      irq_reload   <= 1'b0;
      irq_count    <= '0;
      irq_enabled  <= 1'b0;
      irq_level    <= 1'b0;
      last_a12     <= 1'b0;
      low_count    <= '0;
    end else if (step) begin
      bank_regs    <= bank_regs_next;
      bank_select  <= bank_select_next;
      mirror_reg   <= mirror_reg_next;
      irq_latch    <= irq_latch_next;
      irq_reload   <= irq_reload_next;
      irq_count    <= irq_count_next;
      irq_enabled  <= irq_enabled_next;
      irq_level    <= irq_level_next;
      last_a12     <= last_a12_next;
      low_count    <= low_count_next;
    end
  end

  assign view.bank_regs   = bank_regs;
  assign view.bank_select = bank_select;
  assign irq_after        = irq_level_next;
  assign mirror_after     = mirror_reg_next[0];

endmodule

// ===== design/bmsi_map.sv =====
// Address mapping: CPU reads to PRG ROM or work RAM, CPU writes to work RAM,
// PPU accesses to CHR. Purely combinational; depends on bmsi_pkg.
module bmsi_map (
  input  bmsi_pkg::item_t     item,
  input  bmsi_pkg::map_view_t view,
  input  bmsi_pkg::cfg_t      cfg,
  output bmsi_pkg::target_t   target,
  output logic [bmsi_pkg::MEM_ADDR_W-1:0] mem_addr
);
  import bmsi_pkg::*;

  logic [1:0] prg_slot;
  logic [7:0] second_last, prg_pick, prg_bank;
  logic [2:0] chr_slot;
  logic [7:0] chr_pick, chr_bank;
  logic       wram_hit;
  logic [MEM_ADDR_W-1:0] prg_addr, chr_addr, wram_addr;

  assign prg_slot    = item.cpu_addr[14:13];
  assign second_last = (cfg.prg_bank_mask - 8'd1) & cfg.prg_bank_mask;

  always_comb begin
    priority if (prg_slot == 2'd1) prg_pick = view.bank_regs[7];
    else if (prg_slot == 2'd3)     prg_pick = cfg.prg_bank_mask;
    else if ((prg_slot == 2'd0) != view.bank_select[6]) prg_pick = view.bank_regs[6];
    else                           prg_pick = second_last;
  end

  assign prg_bank = prg_pick & cfg.prg_bank_mask;
  assign prg_addr = MEM_ADDR_W'({prg_bank[PRG_BANK_BITS-1:0], item.cpu_addr[12:0]});

  // inverted CHR layout swaps the 2K pair half with the 1K half
  assign chr_slot = item.ppu_addr[12:10] ^ {view.bank_select[7], 2'b00};

  always_comb begin
    if (!chr_slot[2]) chr_pick = {view.bank_regs[{2'b00, chr_slot[1]}][7:1], chr_slot[0]};
    else              chr_pick = view.bank_regs[chr_slot - 3'd2];
  end

  assign chr_bank = chr_pick & cfg.chr_bank_mask;
  assign chr_addr = MEM_ADDR_W'({chr_bank[CHR_BANK_BITS-1:0], item.ppu_addr[9:0]});

  assign wram_hit  = item.cpu_addr[15:13] == 3'b011;
  assign wram_addr = MEM_ADDR_W'(item.cpu_addr[12:0]);

  always_comb begin
    target   = TGT_NONE;
    mem_addr = '0;
    unique case (item.op)
      OP_WRITE: begin
        if (wram_hit) begin
          target   = TGT_WRAM;
          mem_addr = wram_addr;
        end
      end
      OP_READ: begin
        if (wram_hit) begin
          target   = TGT_WRAM;
          mem_addr = wram_addr;
        end else if (item.cpu_addr[15]) begin
          target   = TGT_PRG;
          mem_addr = prg_addr;
        end
      end
      OP_PPU: begin
        if (!item.ppu_addr[13]) begin
          target   = TGT_CHR;
          mem_addr = chr_addr;
        end
      end
      OP_TICK: ;
      default: ;
    endcase
  end

endmodule
